// ----- src/kcff_pkg.sv -----
// Package for the coupler frame filter: field widths, action codes,
// configuration register indexes and the hop decision helper.
// No dependencies.
package kcff_pkg;

  // Field widths
  localparam int ADDR_W    = 16;
  localparam int HOP_W     = 3;
  localparam int ACTION_W  = 2;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;
  localparam int FILTER_W  = 256;

  // Largest hop count allowed on the bus
  localparam logic [HOP_W-1:0] MAX_HOP = HOP_W'(7);

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_IGNORE_TOTALLY = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ROUTE_DEC      = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_IGNORE_ACKED   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_FORWARD_LOCAL  = 2'd3;

  // Routing modes for group frames (any other code routes all)
  localparam logic [MODE_W-1:0] MODE_BLOCK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FILTER = 2'd1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROUTING_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS_VALID = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_BITS_0     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_BITS_1     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_BITS_2     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_BITS_3     = 3'd6;

  // Route a frame with hops left, acknowledge and drop one at zero hop
  function automatic logic [ACTION_W-1:0] hop_action(input logic [HOP_W-1:0] hop);
    logic [ACTION_W-1:0] act;
    if ((hop != '0) && (hop <= MAX_HOP)) begin
      act = ACT_ROUTE_DEC;
    end else begin
      act = ACT_IGNORE_ACKED;
    end
    return act;
  endfunction

endpackage

// ----- src/knx_coupler_frame_filter_top.sv -----
// Coupler frame filter: decides the routing action for one received frame header.
// Uses kcff_pkg for widths, codes and the hop decision.
// An accepted item passes from the input stage into the result register, which drives out_*.
// Throughput: one item per cycle; in_stall rises only when both stages hold items
// and the result side stalls.
// Reset (rst_n low, synchronous): pipeline empties, all configuration registers clear.
module knx_coupler_frame_filter_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [kcff_pkg::ADDR_W-1:0]          in_dest_address,
  input  logic                                 in_dest_is_group,
  input  logic [kcff_pkg::HOP_W-1:0]           in_hop_count,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [kcff_pkg::ACTION_W-1:0]        out_action,
  // Configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [kcff_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kcff_pkg::CFG_DAT_W-1:0]       cfg_data
);
  import kcff_pkg::*;

  // Configuration registers
  logic [MODE_W-1:0]   routing_mode_r;
  logic [ADDR_W-1:0]   own_address_r;
  logic                own_address_valid_r;
  logic [FILTER_W-1:0] filter_bits_r;

  // Input stage
  logic              s1_valid_r;
  logic [ADDR_W-1:0] s1_dest_r;
  logic              s1_group_r;
  logic [HOP_W-1:0]  s1_hop_r;

  // Result stage
  logic                out_valid_r;
  logic [ACTION_W-1:0] out_action_r;

  logic                out_adv;
  logic                s1_load;
  logic [ACTION_W-1:0] action_nxt;
  logic [ACTION_W-1:0] group_act;
  logic [ACTION_W-1:0] indiv_act;
  logic [7:0]          group_idx;
  logic                filter_pass;
  logic [3:0]          d_area;
  logic [3:0]          d_line;
  logic [7:0]          d_dev;
  logic [3:0]          o_area;
  logic [3:0]          o_line;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      routing_mode_r      <= '0;
      own_address_r       <= '0;
      own_address_valid_r <= 1'b0;
      filter_bits_r       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROUTING_MODE:      routing_mode_r       <= cfg_data[MODE_W-1:0];
        REG_OWN_ADDRESS:       own_address_r        <= cfg_data[ADDR_W-1:0];
        REG_OWN_ADDRESS_VALID: own_address_valid_r  <= cfg_data[0];
        REG_FILTER_BITS_0:     filter_bits_r[63:0]    <= cfg_data;
        REG_FILTER_BITS_1:     filter_bits_r[127:64]  <= cfg_data;
        REG_FILTER_BITS_2:     filter_bits_r[191:128] <= cfg_data;
        REG_FILTER_BITS_3:     filter_bits_r[255:192] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: result stage frees when empty or taken; input stage follows it
  assign out_adv  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_adv;
  assign s1_load  = in_valid && !in_stall;

  // Hold the accepted header
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_dest_r  <= in_dest_address;
      s1_group_r <= in_dest_is_group;
      s1_hop_r   <= in_hop_count;
    end
  end

  // Group frames: mode, then table lookup by main and middle group
  assign group_idx   = s1_dest_r[15:8];
  assign filter_pass = filter_bits_r[group_idx];

  always_comb begin
    if (routing_mode_r == MODE_BLOCK) begin
      group_act = ACT_IGNORE_TOTALLY;
    end else if ((routing_mode_r == MODE_FILTER) && !filter_pass) begin
      group_act = ACT_IGNORE_TOTALLY;
    end else begin
      group_act = hop_action(s1_hop_r);
    end
  end

  // Individual frames: line coupler rules on a nonzero own line, else backbone rules
  assign d_area = s1_dest_r[15:12];
  assign d_line = s1_dest_r[11:8];
  assign d_dev  = s1_dest_r[7:0];
  assign o_area = own_address_r[15:12];
  assign o_line = own_address_r[11:8];

  always_comb begin
    if (!own_address_valid_r) begin
      indiv_act = ACT_IGNORE_TOTALLY;
    end else if (o_line != 4'd0) begin
      if ((d_area != o_area) || (d_line == o_line)) begin
        indiv_act = (d_dev == 8'd0) ? ACT_FORWARD_LOCAL : hop_action(s1_hop_r);
      end else begin
        indiv_act = ACT_IGNORE_TOTALLY;
      end
    end else if ((d_area == o_area) && (d_line == 4'd0) && (d_dev == 8'd0)) begin
      indiv_act = ACT_FORWARD_LOCAL;
    end else begin
      indiv_act = hop_action(s1_hop_r);
    end
  end

  assign action_nxt = s1_group_r ? group_act : indiv_act;

  // Advance the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_action_r <= action_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_action = out_action_r;

  // A stalled input means both stages are full and the result side is holding
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without both stages full");

  // An item in the input stage moves into the result stage when it frees
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_adv) |=> out_valid_r)
    else $error("item lost between stages");

  // Block mode drops every group frame
  a_block_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_group_r && out_adv && (routing_mode_r == MODE_BLOCK))
      |=> (out_action_r == ACT_IGNORE_TOTALLY))
    else $error("group frame passed in block mode");

  // Without a valid own address an individual frame is dropped
  a_no_own_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_group_r && out_adv && !own_address_valid_r)
      |=> (out_action_r == ACT_IGNORE_TOTALLY))
    else $error("individual frame passed without own address");

endmodule

// ----- dv/knx_coupler_frame_filter_top_test.sv -----
// Self-checking testbench for knx_coupler_frame_filter_top: directed and random frame headers
// under several filter settings, with random idles on the input, random result-side stalls and a long receiver hold.
// Depends on kcff_pkg and the block itself; expected actions come from a scoreboard class.
module knx_coupler_frame_filter_top_test;
  import kcff_pkg::*;

  // Route-all codes have no name in the package
  localparam logic [MODE_W-1:0] MODE_ROUTE_ALL = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE     = 2'd3;
  localparam int CYCLE_LIMIT = 100000;
  localparam int SETTLE_CYCLES = 3;

  // Predicts the coupler action per frame and holds the actions still owed by the block
  class frame_action_board;
    logic [MODE_W-1:0]   mode;
    logic [ADDR_W-1:0]   own_addr;
    logic                own_valid;
    logic [FILTER_W-1:0] filter_map;
    logic [ACTION_W-1:0] pending_actions[$];
    int                  errors;

    function new();
      mode       = MODE_BLOCK;
      own_addr   = '0;
      own_valid  = 1'b0;
      filter_map = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_ROUTING_MODE:      mode = data[MODE_W-1:0];
        REG_OWN_ADDRESS:       own_addr = data[ADDR_W-1:0];
        REG_OWN_ADDRESS_VALID: own_valid = data[0];
        REG_FILTER_BITS_0:     filter_map[63:0] = data;
        REG_FILTER_BITS_1:     filter_map[127:64] = data;
        REG_FILTER_BITS_2:     filter_map[191:128] = data;
        REG_FILTER_BITS_3:     filter_map[255:192] = data;
        default: ;
      endcase
    endfunction

    // A 3-bit hop count never exceeds the bus maximum, so any hop left routes
    function logic [ACTION_W-1:0] hop_decision(logic [HOP_W-1:0] hop);
      return (hop != '0) ? ACT_ROUTE_DEC : ACT_IGNORE_ACKED;
    endfunction

    function logic [ACTION_W-1:0] route_decision(logic [ADDR_W-1:0] dest, logic grp,
                                                 logic [HOP_W-1:0] hop);
      logic [3:0] d_area;
      logic [3:0] d_line;
      logic [7:0] d_dev;
      logic [3:0] o_area;
      logic [3:0] o_line;
      d_area = dest[15:12];
      d_line = dest[11:8];
      d_dev  = dest[7:0];
      o_area = own_addr[15:12];
      o_line = own_addr[11:8];
      if (grp) begin
        if (mode == MODE_BLOCK) return ACT_IGNORE_TOTALLY;
        if (mode == MODE_FILTER && !filter_map[dest[15:8]]) return ACT_IGNORE_TOTALLY;
        return hop_decision(hop);
      end
      if (!own_valid) return ACT_IGNORE_TOTALLY;
      // Line coupler: outside own subnetwork if area differs or line equals own line
      if (o_line != 4'd0) begin
        if (d_area != o_area || d_line == o_line) begin
          if (d_dev == 8'd0) return ACT_FORWARD_LOCAL;
          return hop_decision(hop);
        end
        return ACT_IGNORE_TOTALLY;
      end
      // Backbone coupler
      if (d_area == o_area && d_line == 4'd0 && d_dev == 8'd0) return ACT_FORWARD_LOCAL;
      return hop_decision(hop);
    endfunction

    function void note_frame(logic [ADDR_W-1:0] dest, logic grp, logic [HOP_W-1:0] hop);
      pending_actions.push_back(route_decision(dest, grp, hop));
    endfunction

    function void check_action(logic [ACTION_W-1:0] act);
      logic [ACTION_W-1:0] want;
      if (pending_actions.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual action %0d", $time, act);
        errors++;
        return;
      end
      want = pending_actions.pop_front();
      if (act !== want) begin
        $display("%0t: action mismatch: expected %0d, actual %0d", $time, want, act);
        errors++;
      end
    endfunction

    function int pending();
      return pending_actions.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ADDR_W-1:0]    in_dest_address = '0;
  logic                 in_dest_is_group = 1'b0;
  logic [HOP_W-1:0]     in_hop_count = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ACTION_W-1:0]  out_action;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  frame_action_board board;
  bit idle_on = 1'b1;
  int hold_cycles = 0;
  int cycle_count = 0;

  knx_coupler_frame_filter_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_dest_address  (in_dest_address),
    .in_dest_is_group (in_dest_is_group),
    .in_hop_count     (in_hop_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_action       (out_action),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Check results and drive the result-side stall
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        board.check_action(out_action);
      end
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_stall <= idle_on && ($urandom_range(0, 99) < 35);
      end
    end
  end

  // Offer one frame, idling first at random, and return at the edge it is taken
  task automatic send_frame(logic [ADDR_W-1:0] dest, logic grp, logic [HOP_W-1:0] hop);
    while (idle_on && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_dest_address  <= dest;
    in_dest_is_group <= grp;
    in_hop_count     <= hop;
    do @(posedge clk); while (in_stall);
    board.note_frame(dest, grp, hop);
  endtask

  // Stop offering and wait until every owed action has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
  endtask

  // Write every register; unused upper data bits carry random junk
  task automatic set_config(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] own, logic own_ok,
                            logic [63:0] f0, logic [63:0] f1, logic [63:0] f2,
                            logic [63:0] f3);
    logic [CFG_DAT_W-1:0] junk;
    junk = {$urandom(), $urandom()};
    junk[MODE_W-1:0] = mode;
    write_reg(REG_ROUTING_MODE, junk);
    junk = {$urandom(), $urandom()};
    junk[ADDR_W-1:0] = own;
    write_reg(REG_OWN_ADDRESS, junk);
    junk = {$urandom(), $urandom()};
    junk[0] = own_ok;
    write_reg(REG_OWN_ADDRESS_VALID, junk);
    write_reg(REG_FILTER_BITS_0, f0);
    write_reg(REG_FILTER_BITS_1, f1);
    write_reg(REG_FILTER_BITS_2, f2);
    write_reg(REG_FILTER_BITS_3, f3);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] own;
    logic [MODE_W-1:0] mode;
    logic [HOP_W-1:0]  hop;
    logic [7:0]        dev;
    logic              grp;
    logic              own_ok;
    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: groups blocked, no own address
    send_frame(16'h0000, 1'b1, 3'd0);
    send_frame(16'hFFFF, 1'b1, 3'd7);
    send_frame(16'h1203, 1'b0, 3'd5);
    drain();

    // Filter mode, line coupler at 1.2.x; table edges and filter misses
    set_config(MODE_FILTER, 16'h1203, 1'b1, 64'h8000_0000_0000_0001, 64'h0, '1,
               64'h8000_0000_0000_0000);
    send_frame(16'h0000, 1'b1, 3'd0);
    send_frame(16'h00FF, 1'b1, 3'd7);
    send_frame(16'h3F12, 1'b1, 3'd3);
    send_frame(16'h4000, 1'b1, 3'd5);
    send_frame(16'hFFFF, 1'b1, 3'd1);
    send_frame(16'hFE00, 1'b1, 3'd0);
    send_frame(16'h3405, 1'b0, 3'd4);
    send_frame(16'h1200, 1'b0, 3'd6);
    send_frame(16'h1277, 1'b0, 3'd0);
    send_frame(16'h1505, 1'b0, 3'd7);
    send_frame(16'h0000, 1'b0, 3'd2);
    send_frame(16'hFFFF, 1'b0, 3'd7);
    drain();

    // Spare mode routes all groups; backbone coupler in area 15
    set_config(MODE_SPARE, 16'hF000, 1'b1, '0, '0, '0, '0);
    send_frame(16'hABCD, 1'b1, 3'd0);
    send_frame(16'h5432, 1'b1, 3'd6);
    send_frame(16'hF000, 1'b0, 3'd0);
    send_frame(16'hF005, 1'b0, 3'd0);
    send_frame(16'h0000, 1'b0, 3'd3);
    send_frame(16'hF100, 1'b0, 3'd1);
    drain();

    // Route all with own address marked invalid, then block with it valid
    set_config(MODE_ROUTE_ALL, 16'hFFFF, 1'b0, '1, '1, '1, '1);
    send_frame(16'hFF00, 1'b0, 3'd7);
    send_frame(16'h1234, 1'b1, 3'd0);
    drain();
    set_config(MODE_BLOCK, 16'h1100, 1'b1, '1, '1, '1, '1);
    send_frame(16'h2222, 1'b1, 3'd4);
    send_frame(16'h2200, 1'b0, 3'd4);
    drain();

    // Random phases, each under its own setting
    for (int p = 0; p < 6; p++) begin
      if (p == 0) begin
        set_config(MODE_FILTER, 16'hFFFF, 1'b1, '1, '1, '1, '1);
      end else if (p == 1) begin
        set_config(MODE_FILTER, 16'h0000, 1'b1, '0, '0, '0, '0);
      end else begin
        mode = ($urandom_range(0, 2) == 0) ? MODE_FILTER : MODE_W'($urandom_range(0, 3));
        own = 16'($urandom());
        if ($urandom_range(0, 2) == 0) own[11:8] = 4'd0;
        own_ok = ($urandom_range(0, 7) != 0);
        set_config(mode, own, own_ok, {$urandom(), $urandom()}, {$urandom(), $urandom()},
                   {$urandom(), $urandom()}, {$urandom(), $urandom()});
      end
      own = board.own_addr;
      idle_on = (p != 3);
      if (p == 2) hold_cycles = 200;
      for (int n = 0; n < 100; n++) begin
        grp = 1'($urandom_range(0, 1));
        hop = ($urandom_range(0, 3) == 0) ? 3'd0 : HOP_W'($urandom_range(0, 7));
        dev = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom());
        dest = 16'($urandom());
        // Bias individual addresses toward the own address to reach each branch
        if (!grp) begin
          case ($urandom_range(0, 3))
            0: dest = 16'($urandom());
            1: dest = {own[15:8], dev};
            2: dest = {own[15:12], ($urandom_range(0, 1) ? 4'd0 : 4'($urandom())), dev};
            default: dest = {4'($urandom()), own[11:8], dev};
          endcase
        end
        send_frame(dest, grp, hop);
      end
      drain();
    end

    if (board.errors == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/kcff_pkg.sv
src/knx_coupler_frame_filter_top.sv
dv/knx_coupler_frame_filter_top_test.sv
